// ----- rtl/core/abm_pkg.sv -----
package abm_pkg;

    localparam int NUM_BREAKPOINTS_DEF = 4;
    localparam int NUM_CONDITIONS_DEF  = 6;
    localparam int HIT_COUNT_WIDTH_DEF = 16;
    localparam int ADDRESS_WIDTH_DEF   = 20;

    localparam int OP_W           = 3;
    localparam int KIND_W         = 3;
    localparam int BP_SEL_W       = 2;
    localparam int CFG_INDEX_W    = 3;
    localparam int WRITABLE_SLOTS = 6;
    localparam int MASK_OUT_W     = 4;
    localparam int HITS_OUT_W     = 16;
    localparam int NUM_HITS_OUT   = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_MASK = 3'd6;

    localparam logic [OP_W-1:0] OP_EXEC     = 3'd0;
    localparam logic [OP_W-1:0] OP_READ     = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
    localparam logic [OP_W-1:0] OP_PORT_IN  = 3'd3;
    localparam logic [OP_W-1:0] OP_PORT_OUT = 3'd4;
    localparam logic [OP_W-1:0] OP_ACK      = 3'd5;

    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EXEC     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PORT_IN  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PORT_OUT = 3'd5;

    // Acknowledge and the unused op codes map to no kind, so they never match.
    function automatic logic [KIND_W-1:0] op_to_kind(input logic [OP_W-1:0] op);
        logic [KIND_W-1:0] kind;
        unique case (op)
            OP_EXEC:     kind = KIND_EXEC;
            OP_READ:     kind = KIND_READ;
            OP_WRITE:    kind = KIND_WRITE;
            OP_PORT_IN:  kind = KIND_PORT_IN;
            OP_PORT_OUT: kind = KIND_PORT_OUT;
            default:     kind = KIND_NONE;
        endcase
        return kind;
    endfunction

endpackage

// ----- rtl/core/abm_cond_cell.sv -----
module abm_cond_cell
    import abm_pkg::*;
#(
    parameter int SLOT            = 0,
    parameter int ADDRESS_WIDTH   = ADDRESS_WIDTH_DEF,
    parameter int NUM_BREAKPOINTS = NUM_BREAKPOINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [ADDRESS_WIDTH+4:0]     i_cfg_data,
    input  logic [NUM_BREAKPOINTS-1:0]   i_active,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [OP_W-1:0]              i_op,
    input  logic [ADDRESS_WIDTH-1:0]     i_addr,
    input  logic [NUM_BREAKPOINTS-1:0]   i_mask,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [OP_W-1:0]              o_op,
    output logic [ADDRESS_WIDTH-1:0]     o_addr,
    output logic [NUM_BREAKPOINTS-1:0]   o_mask
);

    localparam int COND_W = ADDRESS_WIDTH + KIND_W + BP_SEL_W;

    logic [COND_W-1:0]          r_cond;
    logic                       r_valid;
    logic [OP_W-1:0]            r_op;
    logic [ADDRESS_WIDTH-1:0]   r_addr;
    logic [NUM_BREAKPOINTS-1:0] r_mask;
    logic [NUM_BREAKPOINTS-1:0] n_mask;

    logic [ADDRESS_WIDTH-1:0]   cond_addr;
    logic [KIND_W-1:0]          cond_kind;
    logic [BP_SEL_W-1:0]        cond_bp;
    logic                       cond_match;
    logic                       accept;

    assign cond_addr = r_cond[ADDRESS_WIDTH-1:0];
    assign cond_kind = r_cond[ADDRESS_WIDTH+KIND_W-1:ADDRESS_WIDTH];
    assign cond_bp   = r_cond[COND_W-1:ADDRESS_WIDTH+KIND_W];

    assign cond_match = (cond_kind != KIND_NONE) && (cond_kind == op_to_kind(i_op))
                        && (cond_addr == i_addr);

    always_comb begin
        for (int b = 0; b < NUM_BREAKPOINTS; b++) begin
            n_mask[b] = i_mask[b]
                        | (cond_match && (cond_bp == BP_SEL_W'(b)) && i_active[b]);
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cond  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == CFG_INDEX_W'(SLOT)) && (SLOT < WRITABLE_SLOTS)) begin
                r_cond <= i_cfg_data;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_addr <= i_addr;
            r_mask <= n_mask;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_addr  = r_addr;
    assign o_mask  = r_mask;

endmodule

// ----- rtl/core/abm_hit_unit.sv -----
module abm_hit_unit
    import abm_pkg::*;
#(
    parameter int NUM_BREAKPOINTS = NUM_BREAKPOINTS_DEF,
    parameter int HIT_COUNT_WIDTH = HIT_COUNT_WIDTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [OP_W-1:0]                                 i_op,
    input  logic [NUM_BREAKPOINTS-1:0]                      i_mask,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [NUM_BREAKPOINTS-1:0]                      o_mask,
    output logic                                            o_stop,
    output logic [NUM_BREAKPOINTS-1:0][HIT_COUNT_WIDTH-1:0] o_counts
);

    logic                                            r_valid;
    logic [NUM_BREAKPOINTS-1:0]                      r_mask;
    logic                                            r_stop;
    logic                                            n_stop;
    logic [NUM_BREAKPOINTS-1:0][HIT_COUNT_WIDTH-1:0] r_cnt;
    logic [NUM_BREAKPOINTS-1:0][HIT_COUNT_WIDTH-1:0] n_cnt;
    logic                                            accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        for (int b = 0; b < NUM_BREAKPOINTS; b++) begin
            if (i_mask[b] && !(&r_cnt[b])) begin
                n_cnt[b] = r_cnt[b] + HIT_COUNT_WIDTH'(1);
            end else begin
                n_cnt[b] = r_cnt[b];
            end
        end
        if (i_op == OP_ACK) begin
            n_stop = 1'b0;
        end else begin
            n_stop = r_stop | (|i_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stop  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_stop <= n_stop;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mask <= i_mask;
        end
    end

    assign o_valid  = r_valid;
    assign o_mask   = r_mask;
    assign o_stop   = r_stop;
    assign o_counts = r_cnt;

endmodule

// ----- rtl/core/access_breakpoint_matcher.sv -----
// Pipeline: each event passes one stage per condition cell plus the counter and
// output register before its result appears.
// Throughput: one event per cycle; each stage holds when the stage after it is full.
// Reset clears the conditions to kind none, enables all breakpoints, zeroes the hit
// counters and the stop flag, and empties the pipeline.
module access_breakpoint_matcher
    import abm_pkg::*;
#(
    parameter int NUM_BREAKPOINTS = NUM_BREAKPOINTS_DEF,
    parameter int NUM_CONDITIONS  = NUM_CONDITIONS_DEF,
    parameter int HIT_COUNT_WIDTH = HIT_COUNT_WIDTH_DEF,
    parameter int ADDRESS_WIDTH   = ADDRESS_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]                i_cfg_index,
    input  logic [ADDRESS_WIDTH+4:0]              i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: address, zero padding to whole bytes.
    input  logic [((ADDRESS_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // Fields from bit 0: op.
    input  logic [OP_W-1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: hit_mask, stop_flag, hits_zero, hits_one, hits_two,
    // hits_three, zero padding to whole bytes.
    output logic [71:0]                           m_axis_tdata
);

    logic [NUM_BREAKPOINTS-1:0] r_active;

    logic [NUM_CONDITIONS:0]                          c_valid;
    logic [NUM_CONDITIONS:0]                          c_ready;
    logic [NUM_CONDITIONS:0][OP_W-1:0]                c_op;
    logic [NUM_CONDITIONS:0][ADDRESS_WIDTH-1:0]       c_addr;
    logic [NUM_CONDITIONS:0][NUM_BREAKPOINTS-1:0]     c_mask;

    logic [NUM_BREAKPOINTS-1:0]                       out_mask;
    logic                                             out_stop;
    logic [NUM_BREAKPOINTS-1:0][HIT_COUNT_WIDTH-1:0]  out_counts;
    logic [NUM_HITS_OUT-1:0][HITS_OUT_W-1:0]          hits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '1;
        end else if (i_cfg_we && (i_cfg_index == CFG_ACTIVE_MASK)) begin
            r_active <= i_cfg_data[NUM_BREAKPOINTS-1:0];
        end
    end

    assign c_valid[0]    = s_axis_tvalid;
    assign s_axis_tready = c_ready[0];
    assign c_op[0]       = s_axis_tuser;
    assign c_addr[0]     = s_axis_tdata[ADDRESS_WIDTH-1:0];
    assign c_mask[0]     = '0;

    for (genvar g = 0; g < NUM_CONDITIONS; g++) begin : g_cell
        abm_cond_cell #(
            .SLOT            (g),
            .ADDRESS_WIDTH   (ADDRESS_WIDTH),
            .NUM_BREAKPOINTS (NUM_BREAKPOINTS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg_we    (i_cfg_we),
            .i_cfg_index (i_cfg_index),
            .i_cfg_data  (i_cfg_data),
            .i_active    (r_active),
            .i_valid     (c_valid[g]),
            .o_ready     (c_ready[g]),
            .i_op        (c_op[g]),
            .i_addr      (c_addr[g]),
            .i_mask      (c_mask[g]),
            .o_valid     (c_valid[g+1]),
            .i_ready     (c_ready[g+1]),
            .o_op        (c_op[g+1]),
            .o_addr      (c_addr[g+1]),
            .o_mask      (c_mask[g+1])
        );
    end

    abm_hit_unit #(
        .NUM_BREAKPOINTS (NUM_BREAKPOINTS),
        .HIT_COUNT_WIDTH (HIT_COUNT_WIDTH)
    ) u_hit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[NUM_CONDITIONS]),
        .o_ready  (c_ready[NUM_CONDITIONS]),
        .i_op     (c_op[NUM_CONDITIONS]),
        .i_mask   (c_mask[NUM_CONDITIONS]),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_mask   (out_mask),
        .o_stop   (out_stop),
        .o_counts (out_counts)
    );

    for (genvar g = 0; g < NUM_HITS_OUT; g++) begin : g_hits
        if (g < NUM_BREAKPOINTS) begin : g_used
            assign hits[g] = HITS_OUT_W'(out_counts[g]);
        end else begin : g_unused
            assign hits[g] = '0;
        end
    end

    assign m_axis_tdata = {3'b000, hits[3], hits[2], hits[1], hits[0], out_stop,
                           MASK_OUT_W'(out_mask)};

endmodule
